// ===== sv/gge_pkg.sv =====
// ---------------------------------------------------------------------------
// gge_pkg
// Shared types, constants and helpers for the gene expression step core.
// ---------------------------------------------------------------------------
package gge_pkg;

  localparam int COUNT_BITS_DEF     = 16;
  localparam int TIME_FRAC_BITS_DEF = 16;
  localparam int LOG_TABLE_BITS_DEF = 8;

  localparam int RATE_FRAC_BITS = 24;
  localparam int TIME_BITS      = 40;
  localparam int RATE_BITS      = 32;
  localparam int PROD_BITS      = 64;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Register reset values
  localparam logic [31:0] MRNA_BIRTH_RST    = 32'd167772;
  localparam logic [31:0] MRNA_DECAY_RST    = 32'd96909;
  localparam logic [31:0] PROTEIN_BIRTH_RST = 32'd1938180;
  localparam logic [31:0] PROTEIN_DECAY_RST = 32'd3230;
  localparam logic [TIME_BITS-1:0] TIME_LIMIT_RST = 40'd2359296000;

  // Register indexes
  localparam logic [2:0] REG_MRNA_BIRTH    = 3'd0;
  localparam logic [2:0] REG_MRNA_DECAY    = 3'd1;
  localparam logic [2:0] REG_PROTEIN_BIRTH = 3'd2;
  localparam logic [2:0] REG_PROTEIN_DECAY = 3'd3;
  localparam logic [2:0] REG_TIME_LIMIT    = 3'd4;

  // Reaction codes
  localparam logic [2:0] RXN_MRNA_BIRTH    = 3'd0;
  localparam logic [2:0] RXN_MRNA_DECAY    = 3'd1;
  localparam logic [2:0] RXN_PROTEIN_BIRTH = 3'd2;
  localparam logic [2:0] RXN_PROTEIN_DECAY = 3'd3;
  localparam logic [2:0] RXN_NONE          = 3'd4;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Unsigned add that clips at all ones
  function automatic logic [PROD_BITS-1:0] sat_add64(input logic [PROD_BITS-1:0] a,
                                                     input logic [PROD_BITS-1:0] b);
    logic [PROD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PROD_BITS] ? '1 : s[PROD_BITS-1:0];
  endfunction

endpackage

// ===== sv/gge_mul.sv =====
// ---------------------------------------------------------------------------
// gge_mul
// Shared 32x32 unsigned multiplier with registered product.
// ---------------------------------------------------------------------------
module gge_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // Register the product
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// ===== sv/gge_div.sv =====
// ---------------------------------------------------------------------------
// gge_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gge_div #(
  parameter int W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  output logic [W-1:0]        quotient,
  output gge_pkg::div_stat_t  stat
);
  import gge_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  quo_next;
  logic [W:0]    trial;
  logic          ge;
  logic [CW-1:0] cnt;

  // One shift and subtract step
  always_comb begin
    trial    = {rem, quotient[W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
    quo_next = {quotient[W-2:0], ge};
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem       <= '0;
        quotient  <= dividend;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem      <= rem_next;
        quotient <= quo_next;
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/gillespie_gene_expression_step_core.sv =====
// ---------------------------------------------------------------------------
// gillespie_gene_expression_step_core
// One stochastic simulation step of a two-stage gene expression cell.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one transaction per step: tuser is the mode (1 restarts
//   the cell), tdata holds the wait fraction and the pick fraction.
//   m_axis returns one transaction per input: tdata holds time and counts,
//   tuser holds reaction code, finished and rate error flags.
//   cfg writes the four rates and the time limit and is always ready; it must
//   be written only while the core is idle, which the core does not enforce.
// Step sequence:
//   A restart or a finished cell goes straight to loading the output register.
//   A zero total rate: the propensities are summed, then the result is loaded.
//   A full step: the propensities, the leading-one normalization, the squaring
//   rounds on the shared multiplier, the log scaling, the one-bit-per-cycle
//   divider, then the cell update and the load of the output register.
//   One item is in work at a time; s_axis_tready is low meanwhile.
// Reset: rst (synchronous) clears time and counts and loads register defaults.
// Stall: a result waits in the output register; the next item is accepted
//   and processed, and its result is held back until the register frees.
// ---------------------------------------------------------------------------
module gillespie_gene_expression_step_core #(
  parameter int COUNT_BITS     = gge_pkg::COUNT_BITS_DEF,
  parameter int TIME_FRAC_BITS = gge_pkg::TIME_FRAC_BITS_DEF,
  parameter int LOG_TABLE_BITS = gge_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // wait_fraction[31:0], pick_fraction[63:32]
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // elapsed_time[39:0], mrna_count[55:40],
                                      // protein_count[71:56]
  output logic [4:0]  m_axis_tuser,   // reaction[2:0], finished[3], rate_error[4]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [39:0] cfg_data
);
  import gge_pkg::*;

  localparam int LW    = 6 + LOG_TABLE_BITS;
  localparam int RW    = $clog2(LOG_TABLE_BITS);
  localparam int SHIFT = TIME_FRAC_BITS + RATE_FRAC_BITS - LOG_TABLE_BITS - 32;
  localparam int SHL   = (SHIFT > 0) ? SHIFT : 0;
  localparam int SHR   = (SHIFT < 0) ? -SHIFT : 0;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_P1   = 4'd1;
  localparam logic [3:0] ST_P2   = 4'd2;
  localparam logic [3:0] ST_P3   = 4'd3;
  localparam logic [3:0] ST_P4   = 4'd4;
  localparam logic [3:0] ST_NORM = 4'd5;
  localparam logic [3:0] ST_SQI  = 4'd6;
  localparam logic [3:0] ST_SQW  = 4'd7;
  localparam logic [3:0] ST_LNI  = 4'd8;
  localparam logic [3:0] ST_LNW  = 4'd9;
  localparam logic [3:0] ST_TG1  = 4'd10;
  localparam logic [3:0] ST_TG2  = 4'd11;
  localparam logic [3:0] ST_TG3  = 4'd12;
  localparam logic [3:0] ST_DIVW = 4'd13;
  localparam logic [3:0] ST_UPD  = 4'd14;
  localparam logic [3:0] ST_WR   = 4'd15;

  // Configuration registers
  logic [31:0]          mrna_birth_rate;
  logic [31:0]          mrna_decay_rate;
  logic [31:0]          protein_birth_rate;
  logic [31:0]          protein_decay_rate;
  logic [TIME_BITS-1:0] time_limit;

  // Cell state
  logic [TIME_BITS-1:0]  sim_time;
  logic [COUNT_BITS-1:0] mrna_level;
  logic [COUNT_BITS-1:0] protein_level;

  // Working registers
  logic [3:0]                state;
  logic [PROD_BITS-1:0]      c2, c3, k;
  logic [PROD_BITS-1:0]      target_hi, target;
  logic [31:0]               pick;
  logic [31:0]               x;
  logic                      lz;
  logic [4:0]                shamt;
  logic [2:0]                nstep;
  logic [RW-1:0]             rnd;
  logic [LOG_TABLE_BITS-1:0] frac;
  logic [2:0]                rxn;
  logic                      rerr;

  // Shared unit wiring
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          prod;
  logic                 div_start;
  logic [63:0]          div_num;
  logic [63:0]          quotient;
  div_stat_t            div_stat;

  // Local combinational values
  logic [PROD_BITS-1:0] c1;
  logic [PROD_BITS-1:0] k_next;
  logic [LW-1:0]        lval;
  logic [4:0]           amt;
  logic                 top_zero;
  logic [32:0]          sq;
  logic [TIME_BITS-1:0] time_room;
  logic                 time_over;
  logic                 out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign c1     = PROD_BITS'(mrna_birth_rate);
  assign k_next = sat_add64(c3, prod);
  assign lval   = lz ? '0
                     : (LW'((LW'(shamt) + 1'b1) << LOG_TABLE_BITS) - LW'(frac));
  assign amt      = 5'(16 >> nstep);
  assign top_zero = ((x >> (6'd32 - 6'(amt))) == 32'd0);
  assign sq       = prod[63:31];
  assign time_room = TIME_MAX - sim_time;
  assign time_over = (quotient[63:40] != '0) || (quotient[39:0] > time_room);

  assign div_start = (state == ST_LNW);
  assign div_num   = (prod << SHL) >> SHR;

  // Select operands of the shared multiplier
  always_comb begin
    unique case (state)
      ST_P1:   begin mul_a = mrna_decay_rate;    mul_b = 32'(mrna_level);    end
      ST_P2:   begin mul_a = protein_birth_rate; mul_b = 32'(mrna_level);    end
      ST_P3:   begin mul_a = protein_decay_rate; mul_b = 32'(protein_level); end
      ST_SQI:  begin mul_a = x;                  mul_b = x;                  end
      ST_LNI:  begin mul_a = 32'(lval);          mul_b = LN2_Q32;            end
      ST_TG1:  begin mul_a = pick;               mul_b = k[63:32];           end
      ST_TG2:  begin mul_a = pick;               mul_b = k[31:0];            end
      default: begin mul_a = '0;                 mul_b = '0;                 end
    endcase
  end

  gge_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  gge_div #(.W(PROD_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (k),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mrna_birth_rate    <= MRNA_BIRTH_RST;
      mrna_decay_rate    <= MRNA_DECAY_RST;
      protein_birth_rate <= PROTEIN_BIRTH_RST;
      protein_decay_rate <= PROTEIN_DECAY_RST;
      time_limit         <= TIME_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MRNA_BIRTH:    mrna_birth_rate    <= cfg_data[31:0];
        REG_MRNA_DECAY:    mrna_decay_rate    <= cfg_data[31:0];
        REG_PROTEIN_BIRTH: protein_birth_rate <= cfg_data[31:0];
        REG_PROTEIN_DECAY: protein_decay_rate <= cfg_data[31:0];
        REG_TIME_LIMIT:    time_limit         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sim_time      <= '0;
      mrna_level    <= '0;
      protein_level <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded now
      if (m_axis_tvalid && m_axis_tready && (state != ST_WR)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            rxn   <= RXN_NONE;
            rerr  <= 1'b0;
            x     <= s_axis_tdata[31:0];
            lz    <= (s_axis_tdata[31:0] == 32'd0);
            pick  <= s_axis_tdata[63:32];
            shamt <= '0;
            nstep <= '0;
            if (s_axis_tuser) begin
              sim_time      <= '0;
              mrna_level    <= '0;
              protein_level <= '0;
              state         <= ST_WR;
            end else if (sim_time >= time_limit) begin
              state <= ST_WR;
            end else begin
              state <= ST_P1;
            end
          end
        end
        ST_P1: state <= ST_P2;
        ST_P2: begin
          c2    <= sat_add64(c1, prod);
          state <= ST_P3;
        end
        ST_P3: begin
          c3    <= sat_add64(c2, prod);
          state <= ST_P4;
        end
        ST_P4: begin
          k <= k_next;
          if (k_next == '0) begin
            rerr  <= 1'b1;
            state <= ST_WR;
          end else begin
            state <= ST_NORM;
          end
        end
        // Normalize the wait fraction by 16, 8, 4, 2, 1 bit shifts
        ST_NORM: begin
          if (top_zero) begin
            x     <= x << amt;
            shamt <= shamt + amt;
          end
          nstep <= nstep + 1'b1;
          if (nstep == 3'd4) begin
            rnd   <= '0;
            frac  <= '0;
            state <= ST_SQI;
          end
        end
        ST_SQI: state <= ST_SQW;
        // One fraction bit per squaring round
        ST_SQW: begin
          frac <= {frac[LOG_TABLE_BITS-2:0], sq[32]};
          x    <= sq[32] ? sq[32:1] : sq[31:0];
          rnd  <= rnd + 1'b1;
          state <= (rnd == RW'(LOG_TABLE_BITS - 1)) ? ST_LNI : ST_SQI;
        end
        ST_LNI: state <= ST_LNW;
        ST_LNW: state <= ST_TG1;
        ST_TG1: state <= ST_TG2;
        ST_TG2: begin
          target_hi <= prod;
          state     <= ST_TG3;
        end
        ST_TG3: begin
          target <= target_hi + (prod >> 32);
          state  <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            state <= ST_UPD;
          end
        end
        // Advance time and fire the chosen reaction
        ST_UPD: begin
          sim_time <= time_over ? TIME_MAX : sim_time + quotient[39:0];
          if (target < c1) begin
            rxn <= RXN_MRNA_BIRTH;
            if (mrna_level != COUNT_MAX) mrna_level <= mrna_level + 1'b1;
          end else if (target < c2) begin
            rxn <= RXN_MRNA_DECAY;
            if (mrna_level != '0) mrna_level <= mrna_level - 1'b1;
          end else if (target < c3) begin
            rxn <= RXN_PROTEIN_BIRTH;
            if (protein_level != COUNT_MAX) protein_level <= protein_level + 1'b1;
          end else begin
            rxn <= RXN_PROTEIN_DECAY;
            if (protein_level != '0) protein_level <= protein_level - 1'b1;
          end
          state <= ST_WR;
        end
        // Load the output register once it is free
        ST_WR: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {16'(protein_level), 16'(mrna_level), sim_time};
            m_axis_tuser  <= {rerr, (sim_time >= time_limit), rxn};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LNW) |=> div_stat.busy)
    else $error("divider not running after start");

  a_err_no_rxn: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[4]) |-> (m_axis_tuser[2:0] == RXN_NONE))
    else $error("rate error with a reaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != ST_IDLE))
    else $error("sequencer idle after accept");
`endif

endmodule
